// ----- hw/rtl/nsfp_pkg.sv -----
`default_nettype none
package nsfp_pkg;

	// longest character-array field kept, and number of satellite slots
	localparam int unsigned FIELD_CHARS = 16;
	localparam int unsigned MAX_SATS    = 12;

	// sentence kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_GGA  = 3'd1;
	localparam logic [2:0] KIND_GSA  = 3'd2;
	localparam logic [2:0] KIND_GSV  = 3'd3;
	localparam logic [2:0] KIND_RMC  = 3'd4;

	// characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_X      = 8'h78;

	// destination field codes
	localparam logic [4:0] FC_FIX        = 5'd0;
	localparam logic [4:0] FC_SATS_USED  = 5'd1;
	localparam logic [4:0] FC_ALT        = 5'd2;
	localparam logic [4:0] FC_HOUR       = 5'd3;
	localparam logic [4:0] FC_MIN        = 5'd4;
	localparam logic [4:0] FC_SEC        = 5'd5;
	localparam logic [4:0] FC_DAY        = 5'd6;
	localparam logic [4:0] FC_MONTH      = 5'd7;
	localparam logic [4:0] FC_YEAR       = 5'd8;
	localparam logic [4:0] FC_RMC_STATUS = 5'd9;
	localparam logic [4:0] FC_LAT        = 5'd10;
	localparam logic [4:0] FC_NS         = 5'd11;
	localparam logic [4:0] FC_LON        = 5'd12;
	localparam logic [4:0] FC_EW         = 5'd13;
	localparam logic [4:0] FC_SPEED      = 5'd14;
	localparam logic [4:0] FC_COURSE     = 5'd15;
	localparam logic [4:0] FC_PRN        = 5'd16;
	localparam logic [4:0] FC_GSA_MODE   = 5'd17;
	localparam logic [4:0] FC_FIX_MODE   = 5'd18;
	localparam logic [4:0] FC_PDOP       = 5'd19;
	localparam logic [4:0] FC_HDOP       = 5'd20;
	localparam logic [4:0] FC_VDOP       = 5'd21;
	localparam logic [4:0] FC_IN_VIEW    = 5'd22;
	localparam logic [4:0] FC_SAT_ID     = 5'd23;
	localparam logic [4:0] FC_SNR        = 5'd24;
	localparam logic [4:0] FC_RMC_DONE   = 5'd25;

	typedef struct packed {
		logic       in_sentence;
		logic       type_known;
		logic [2:0] kind;
		logic [2:0] type_cnt;
		logic [7:0] ch4;
		logic [7:0] ch5;
		logic [7:0] field_num;
		logic [7:0] char_pos;
		logic [7:0] tens;
		logic [3:0] sat_slot;
	} nsfp_state_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] code;
		logic [3:0] slot;
		logic [7:0] value;
	} nsfp_result_t;

	localparam nsfp_state_t ST_RESET = '{
		in_sentence: 1'b0,
		type_known:  1'b0,
		kind:        KIND_NONE,
		type_cnt:    3'd0,
		ch4:         CH_X,
		ch5:         CH_X,
		field_num:   8'd0,
		char_pos:    8'd0,
		tens:        8'd0,
		sat_slot:    4'd0
	};

	function automatic nsfp_result_t mk_result(input logic [4:0] code, input logic [3:0] slot,
			input logic [7:0] value);
		nsfp_result_t r;
		r.valid = 1'b1;
		r.code  = code;
		r.slot  = slot;
		r.value = value;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/nsfp_step.sv -----
`default_nettype none
module nsfp_step
	import nsfp_pkg::*;
(
	input  wire nsfp_state_t  cur,
	input  wire logic [7:0]   rx_byte,
	output nsfp_state_t       nxt,
	output nsfp_result_t      res
);

	logic [7:0] f;
	logic [7:0] pos;
	logic [7:0] digit;
	logic [7:0] two_dig;
	logic [7:0] field_inc;
	logic [7:0] pos_inc;
	logic [2:0] cnt_inc;
	logic       pos_ok;
	logic [2:0] new_kind;

	assign f         = cur.field_num;
	assign pos       = cur.char_pos;
	assign digit     = rx_byte - CH_ZERO;
	assign two_dig   = cur.tens * 8'd10 + rx_byte - CH_ZERO;
	assign field_inc = cur.field_num + 8'd1;
	assign pos_inc   = (cur.char_pos == 8'hFF) ? cur.char_pos : cur.char_pos + 8'd1;
	assign cnt_inc   = cur.type_cnt + 3'd1;
	assign pos_ok    = (pos < 8'(FIELD_CHARS)) && (pos <= 8'd15);

	// later tests win
	always_comb begin
		new_kind = KIND_NONE;
		if (cur.ch4 == CH_G && cur.ch5 == CH_A) new_kind = KIND_GGA;
		if (cur.ch4 == CH_S && cur.ch5 == CH_A) new_kind = KIND_GSA;
		if (cur.ch5 == CH_V) new_kind = KIND_GSV;
		if (cur.ch5 == CH_C) new_kind = KIND_RMC;
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (!cur.in_sentence) begin
			if (rx_byte == CH_DOLLAR) begin
				nxt.in_sentence = 1'b1;
				nxt.type_cnt    = 3'd1;
				nxt.type_known  = 1'b0;
				nxt.kind        = KIND_NONE;
				nxt.field_num   = 8'd0;
				nxt.char_pos    = 8'd0;
			end
		end else if (!cur.type_known) begin
			if (rx_byte == CH_COMMA) begin
				nxt.kind       = new_kind;
				nxt.type_known = 1'b1;
				nxt.type_cnt   = 3'd1;
				nxt.field_num  = 8'd0;
				nxt.char_pos   = 8'd0;
			end else if (rx_byte == CH_STAR) begin
				nxt.in_sentence = 1'b0;
			end else begin
				if (cur.type_cnt == 3'd4) nxt.ch4 = rx_byte;
				else if (cur.type_cnt == 3'd5) nxt.ch5 = rx_byte;
				nxt.type_cnt = cnt_inc;
				if (cnt_inc == 3'd7 || cnt_inc == 3'd0) nxt.in_sentence = 1'b0;
			end
		end else if (cur.kind == KIND_NONE) begin
			// unknown type: this byte is swallowed
			nxt.kind        = KIND_NONE;
			nxt.type_known  = 1'b0;
			nxt.type_cnt    = 3'd1;
			nxt.in_sentence = 1'b0;
		end else if (rx_byte == CH_STAR) begin
			nxt.in_sentence = 1'b0;
			if (cur.kind == KIND_RMC) res = mk_result(FC_RMC_DONE, 4'd0, 8'd0);
		end else if (rx_byte == CH_COMMA) begin
			nxt.char_pos = 8'd0;
			if (cur.field_num != 8'hFF) begin
				nxt.field_num = field_inc;
				if (cur.kind == KIND_GSA && field_inc >= 8'd2 && field_inc <= 8'd13)
					res = mk_result(FC_PRN, 4'(field_inc - 8'd2), 8'd0);
			end
		end else begin
			nxt.char_pos = pos_inc;
			case (cur.kind)
				KIND_GGA: begin
					case (f)
						8'd5: res = mk_result(FC_FIX, 4'd0, rx_byte);
						8'd6: if (pos_ok) res = mk_result(FC_SATS_USED, pos[3:0], rx_byte);
						8'd8: if (pos_ok) res = mk_result(FC_ALT, pos[3:0], rx_byte);
						default: ;
					endcase
				end
				KIND_RMC: begin
					case (f)
						8'd0, 8'd8: begin
							case (pos)
								8'd0, 8'd2, 8'd4: nxt.tens = digit;
								8'd1: res = mk_result((f == 8'd0) ? FC_HOUR : FC_DAY, 4'd0, two_dig);
								8'd3: res = mk_result((f == 8'd0) ? FC_MIN : FC_MONTH, 4'd0, two_dig);
								8'd5: res = mk_result((f == 8'd0) ? FC_SEC : FC_YEAR, 4'd0, two_dig);
								default: ;
							endcase
						end
						8'd1: res = mk_result(FC_RMC_STATUS, 4'd0, rx_byte);
						8'd2: if (pos_ok) res = mk_result(FC_LAT, pos[3:0], rx_byte);
						8'd3: res = mk_result(FC_NS, 4'd0, rx_byte);
						8'd4: if (pos_ok) res = mk_result(FC_LON, pos[3:0], rx_byte);
						8'd5: res = mk_result(FC_EW, 4'd0, rx_byte);
						8'd6: if (pos_ok) res = mk_result(FC_SPEED, pos[3:0], rx_byte);
						8'd7: if (pos_ok) res = mk_result(FC_COURSE, pos[3:0], rx_byte);
						default: ;
					endcase
				end
				KIND_GSA: begin
					case (f) inside
						8'd0: res = mk_result(FC_GSA_MODE, 4'd0, rx_byte);
						8'd1: res = mk_result(FC_FIX_MODE, 4'd0, rx_byte);
						[8'd2:8'd13]: begin
							if (pos == 8'd0) nxt.tens = digit;
							else if (pos == 8'd1) res = mk_result(FC_PRN, 4'(f - 8'd2), two_dig);
						end
						8'd14: if (pos_ok) res = mk_result(FC_PDOP, pos[3:0], rx_byte);
						8'd15: if (pos_ok) res = mk_result(FC_HDOP, pos[3:0], rx_byte);
						8'd16: if (pos_ok) res = mk_result(FC_VDOP, pos[3:0], rx_byte);
						default: ;
					endcase
				end
				default: begin
					// satellites in view
					if (f == 8'd1) begin
						if (rx_byte == CH_ONE) nxt.sat_slot = 4'd0;
					end else if (f == 8'd2 || (f >= 8'd3 && f <= 8'd18 && f[1])) begin
						if (pos == 8'd0) begin
							nxt.tens = digit;
						end else if (pos == 8'd1) begin
							if (f == 8'd2) begin
								res = mk_result(FC_IN_VIEW, 4'd0, two_dig);
							end else if (f[0]) begin
								if (cur.sat_slot < 4'(MAX_SATS)) begin
									res = mk_result(FC_SAT_ID, cur.sat_slot, two_dig);
									nxt.sat_slot = cur.sat_slot + 4'd1;
								end
							end else if (cur.sat_slot != 4'd0) begin
								res = mk_result(FC_SNR, cur.sat_slot - 4'd1, two_dig);
							end
						end
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/nmea_sentence_field_parser_core.sv -----
`default_nettype none
// channel   dir  tdata fields (low bit up)                       tlast/tuser
// s_*       in   rx_byte[7:0]                                    none
// m_*       out  field_code[4:0], slot[8:5], value[16:9], zero   none
//
// one byte per cycle sustained while the output is not stalled: a byte is taken into
// the input register, parsed by the next-state logic once the output register is free,
// and its field write, if any, lands in the output register at the end of that cycle
// bytes that give no field write are consumed without touching the output
// reset clears the parser state to "waiting for '$'" with type chars 'x'
// a stalled output register holds the input register, which then drops s_tready
module nmea_sentence_field_parser_core
	import nsfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // field_code[4:0], slot[8:5], value[16:9], zeros
);

	// input register
	logic         valid_s1;
	logic [7:0]   byte_s1;

	// parser state
	nsfp_state_t  state_q;
	nsfp_state_t  state_nxt;
	nsfp_result_t step_res;

	// output register
	logic         out_valid_q;
	logic [4:0]   code_q;
	logic [3:0]   slot_q;
	logic [7:0]   value_q;

	logic         out_free;
	logic         advance;

	// output register can take a new result this cycle
	assign out_free = !out_valid_q || m_tready;
	// the byte held in stage 1 is parsed and retired
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	nsfp_step u_step (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: loaded on every retired byte that writes a field,
	// emptied once the downstream takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && step_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			code_q  <= step_res.code;
			slot_q  <= step_res.slot;
			value_q <= step_res.value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, value_q, slot_q, code_q};

	// a type that was never recognized always carries no kind
	a_kind_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.type_known |-> state_q.kind == KIND_NONE)
		else $error("type not known but kind set");

	// kind stays within the known set
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.kind <= KIND_RMC)
		else $error("sentence kind out of range");

	// while the type is collected the count is in 1..6
	a_type_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_sentence && !state_q.type_known |->
		state_q.type_cnt != 3'd0 && state_q.type_cnt != 3'd7)
		else $error("type char count out of range");

	// a retired byte with a field write shows up at the output next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.valid |=> out_valid_q)
		else $error("field write lost");

	// completion marker has no payload
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && code_q == FC_RMC_DONE |-> slot_q == 4'd0 && value_q == 8'd0)
		else $error("completion result carries payload");

endmodule
`default_nettype wire

// ----- tb/nmea_sentence_field_parser_core_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nmea_sentence_field_parser_core_tb;
	import nsfp_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_TICKS = 11;
	localparam int RANDOM_BYTES = 870;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_TICKS  = 8;

	typedef struct packed {
		logic [4:0] code;
		logic [3:0] slot;
		logic [7:0] value;
	} field_write_t;

	// receiver stall patterns
	typedef enum int {RX_FLOW, RX_RANDOM, RX_EVERY_THIRD, RX_LONG_STALLS} rx_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;    // rx_byte[7:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;             // field_code[4:0], slot[8:5], value[16:9], zeros

	nmea_sentence_field_parser_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial forever #CLK_HALF clk = ~clk;

	// bytes waiting for the driver; bit 8 holds the byte back until all writes are in
	logic [8:0]   stim_bytes[$];
	field_write_t writes_due[$];

	int          fail_count     = 0;
	int          writes_seen    = 0;
	int          bytes_taken    = 0;
	int          sentence_bytes = 0;
	int          sentence_count = 0;
	int          cycle_count    = 0;
	logic [31:0] codes_seen     = '0;

	// parser model state
	logic       in_sentence;
	logic       type_known;
	logic [2:0] kind;
	logic [2:0] type_count;
	logic [7:0] type_ch4;
	logic [7:0] type_ch5;
	logic [7:0] field_idx;
	logic [7:0] char_idx;
	logic [7:0] tens;
	logic [3:0] sat_idx;

	function automatic void parser_reset();
		in_sentence = 1'b0;
		type_known  = 1'b0;
		kind        = KIND_NONE;
		type_count  = 3'd0;
		type_ch4    = CH_X;
		type_ch5    = CH_X;
		field_idx   = 8'd0;
		char_idx    = 8'd0;
		tens        = 8'd0;
		sat_idx     = 4'd0;
	endfunction

	function automatic void add_write(input logic [4:0] code, input logic [3:0] slot,
			input logic [7:0] value);
		field_write_t w;
		w.code  = code;
		w.slot  = slot;
		w.value = value;
		writes_due.push_back(w);
	endfunction

	// character-array fields keep only the first positions
	function automatic void keep_char(input logic [7:0] b, input logic [4:0] code);
		if (char_idx < FIELD_CHARS && char_idx <= 8'd15)
			add_write(code, char_idx[3:0], b);
	endfunction

	// hhmmss / ddmmyy: tens digit at even positions, value written at odd ones
	function automatic void time_pair(input logic [7:0] b, input logic [7:0] pair,
			input logic [4:0] c1, input logic [4:0] c3, input logic [4:0] c5);
		case (char_idx)
		8'd0, 8'd2, 8'd4: tens = b - CH_ZERO;
		8'd1: add_write(c1, 4'd0, pair);
		8'd3: add_write(c3, 4'd0, pair);
		8'd5: add_write(c5, 4'd0, pair);
		default: ;
		endcase
	endfunction

	// one character inside a field of a known sentence
	function automatic void field_char(input logic [7:0] b);
		logic [7:0] pair;
		logic [7:0] f;
		logic [7:0] prn;
		f    = field_idx;
		pair = tens * 8'd10 + b - CH_ZERO;
		prn  = f - 8'd2;
		case (kind)
		KIND_GGA: begin
			if (f == 8'd5) add_write(FC_FIX, 4'd0, b);
			else if (f == 8'd6) keep_char(b, FC_SATS_USED);
			else if (f == 8'd8) keep_char(b, FC_ALT);
		end
		KIND_RMC: begin
			case (f)
			8'd0: time_pair(b, pair, FC_HOUR, FC_MIN, FC_SEC);
			8'd1: add_write(FC_RMC_STATUS, 4'd0, b);
			8'd2: keep_char(b, FC_LAT);
			8'd3: add_write(FC_NS, 4'd0, b);
			8'd4: keep_char(b, FC_LON);
			8'd5: add_write(FC_EW, 4'd0, b);
			8'd6: keep_char(b, FC_SPEED);
			8'd7: keep_char(b, FC_COURSE);
			8'd8: time_pair(b, pair, FC_DAY, FC_MONTH, FC_YEAR);
			default: ;
			endcase
		end
		KIND_GSA: begin
			if (f == 8'd0) add_write(FC_GSA_MODE, 4'd0, b);
			else if (f == 8'd1) add_write(FC_FIX_MODE, 4'd0, b);
			else if (f >= 8'd2 && f <= 8'd13) begin
				if (char_idx == 8'd0) tens = b - CH_ZERO;
				else if (char_idx == 8'd1) add_write(FC_PRN, prn[3:0], pair);
			end
			else if (f == 8'd14) keep_char(b, FC_PDOP);
			else if (f == 8'd15) keep_char(b, FC_HDOP);
			else if (f == 8'd16) keep_char(b, FC_VDOP);
		end
		KIND_GSV: begin
			if (f == 8'd1) begin
				// message number one restarts the satellite slots
				if (b == CH_ONE) sat_idx = 4'd0;
			end else if (f >= 8'd2 && f <= 8'd18 && f[1]) begin
				if (char_idx == 8'd0) tens = b - CH_ZERO;
				else if (char_idx == 8'd1) begin
					if (f == 8'd2) add_write(FC_IN_VIEW, 4'd0, pair);
					else if (f[0]) begin
						if (sat_idx < MAX_SATS) begin
							add_write(FC_SAT_ID, sat_idx, pair);
							sat_idx = sat_idx + 4'd1;
						end
					end else if (sat_idx != 4'd0) add_write(FC_SNR, sat_idx - 4'd1, pair);
				end
			end
		end
		default: ;
		endcase
		if (char_idx != 8'd255) char_idx = char_idx + 8'd1;
	endfunction

	// advance the model by one accepted byte
	function automatic void parse_byte(input logic [7:0] b);
		logic [7:0] prn;
		if (!in_sentence) begin
			if (b == CH_DOLLAR) begin
				in_sentence = 1'b1;
				type_count  = 3'd1;
				type_known  = 1'b0;
				kind        = KIND_NONE;
				field_idx   = 8'd0;
				char_idx    = 8'd0;
			end
		end else if (!type_known) begin
			if (b == CH_COMMA) begin
				// later tests win, type chars four and five persist
				kind = KIND_NONE;
				if (type_ch4 == CH_G && type_ch5 == CH_A) kind = KIND_GGA;
				if (type_ch4 == CH_S && type_ch5 == CH_A) kind = KIND_GSA;
				if (type_ch5 == CH_V) kind = KIND_GSV;
				if (type_ch5 == CH_C) kind = KIND_RMC;
				type_known = 1'b1;
				type_count = 3'd1;
				field_idx  = 8'd0;
				char_idx   = 8'd0;
			end else if (b == CH_STAR) begin
				in_sentence = 1'b0;
			end else begin
				if (type_count == 3'd4) type_ch4 = b;
				else if (type_count == 3'd5) type_ch5 = b;
				type_count = type_count + 3'd1;
				if (type_count == 3'd7 || type_count == 3'd0) in_sentence = 1'b0;
			end
		end else if (kind == KIND_NONE) begin
			// unknown type: this byte is swallowed and the parser starts over
			type_known  = 1'b0;
			type_count  = 3'd1;
			in_sentence = 1'b0;
		end else if (b == CH_STAR) begin
			in_sentence = 1'b0;
			if (kind == KIND_RMC) add_write(FC_RMC_DONE, 4'd0, 8'd0);
		end else if (b == CH_COMMA) begin
			if (field_idx != 8'd255) begin
				field_idx = field_idx + 8'd1;
				prn = field_idx - 8'd2;
				if (kind == KIND_GSA && field_idx >= 8'd2 && field_idx <= 8'd13)
					add_write(FC_PRN, prn[3:0], 8'd0);
			end
			char_idx = 8'd0;
		end else begin
			field_char(b);
		end
	endfunction

	// ---- stimulus building ----

	function automatic void push_char(input logic [7:0] c);
		stim_bytes.push_back({1'b0, c});
		sentence_bytes++;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endfunction

	function automatic logic [7:0] field_byte();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			c = 8'($urandom_range(0, 9));
			c = c + CH_ZERO;
		end else if (r < 97) begin
			do c = 8'($urandom_range(33, 126)); while (c == CH_COMMA || c == CH_STAR);
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// mostly digit pairs, now and then fields long enough to run off the arrays
	function automatic int field_len(input logic [2:0] k, input int f);
		int r;
		r = $urandom_range(0, 99);
		if (k == KIND_RMC && (f == 0 || f == 8) && r < 70) return $urandom_range(6, 10);
		if (r < 55) return $urandom_range(1, 2);
		if (r < 85) return $urandom_range(0, 6);
		if (r < 97) return $urandom_range(7, 14);
		return $urandom_range(15, 22);
	endfunction

	// fields after the type comma, then usually '*', checksum and line end
	function automatic void push_body(input logic [2:0] k, input int nf);
		for (int f = 0; f < nf; f++) begin
			if (f > 0) push_char(CH_COMMA);
			if (k == KIND_GSV && f == 1 && $urandom_range(0, 99) < 65) push_char(CH_ONE);
			else repeat (field_len(k, f)) push_char(field_byte());
		end
		if ($urandom_range(0, 99) < 92) begin
			push_char(CH_STAR);
			push_text("5A");
			push_char(8'h0D);
			push_char(8'h0A);
		end
	endfunction

	function automatic void push_sentence(input logic [2:0] k, input logic drain_first);
		string tag;
		int    nf;
		case (k)
		KIND_GGA: begin
			tag = $urandom_range(0, 1) ? "GPGGA" : "GNGGA";
			nf  = $urandom_range(4, 15);
		end
		KIND_GSA: begin
			tag = $urandom_range(0, 1) ? "GPGSA" : "GNGSA";
			nf  = $urandom_range(2, 18);
		end
		KIND_GSV: begin
			tag = $urandom_range(0, 1) ? "GPGSV" : "GLGSV";
			nf  = $urandom_range(1, 20);
		end
		default: begin
			tag = $urandom_range(0, 1) ? "GPRMC" : "GNRMC";
			nf  = $urandom_range(1, 13);
		end
		endcase
		stim_bytes.push_back({drain_first, CH_DOLLAR});
		sentence_bytes++;
		sentence_count++;
		push_text(tag);
		push_char(CH_COMMA);
		push_body(k, nf);
	endfunction

	function automatic logic [7:0] any_letter();
		logic [7:0] c;
		c = 8'($urandom_range(8'h41, 8'h5A));
		return c;
	endfunction

	// ---- driver: bursts of transfers with random gaps ----

	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		logic       next_valid;
		logic [7:0] next_data;
		logic [8:0] entry;
		next_valid = s_tvalid;
		next_data  = s_tdata;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
				bytes_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (stim_bytes.size() != 0 &&
						!(stim_bytes[0][8] && writes_due.size() != 0)) begin
					entry      = stim_bytes.pop_front();
					next_valid = 1'b1;
					next_data  = entry[7:0];
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left--;
					end
				end
			end
		end
		s_tvalid <= next_valid;
		s_tdata  <= next_data;
	end

	// ---- monitor: checks field writes, drives the stall pattern ----

	rx_mode_t stall_mode = RX_FLOW;
	int       mode_left  = 0;
	int       run_left   = 0;
	int       tick       = 0;
	logic     hold_low   = 1'b0;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		fail_count++;
		$display("[%0t] field write %0d: %s is 0x%0h, expected 0x%0h",
			$time, writes_seen, what, got, want);
	endtask

	always @(posedge clk) begin
		field_write_t want;
		logic         next_ready;
		next_ready = m_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				writes_seen++;
				codes_seen[m_tdata[4:0]] = 1'b1;
				if (writes_due.size() == 0) begin
					report_mismatch("write with nothing pending, tdata", 32'(m_tdata), 0);
				end else begin
					want = writes_due.pop_front();
					if (m_tdata[4:0] != want.code)
						report_mismatch("field_code", 32'(m_tdata[4:0]), 32'(want.code));
					if (m_tdata[8:5] != want.slot)
						report_mismatch("slot", 32'(m_tdata[8:5]), 32'(want.slot));
					if (m_tdata[16:9] != want.value)
						report_mismatch("value", 32'(m_tdata[16:9]), 32'(want.value));
					if (m_tdata[23:17] != '0)
						report_mismatch("pad bits", 32'(m_tdata[23:17]), 0);
				end
			end
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 150);
			end
			mode_left--;
			tick++;
			case (stall_mode)
			RX_FLOW: next_ready = 1'b1;
			RX_RANDOM: next_ready = ($urandom_range(0, 3) != 0);
			RX_EVERY_THIRD: next_ready = (tick % 3 == 0);
			default: begin
				if (run_left == 0) begin
					hold_low = !hold_low;
					run_left = hold_low ? $urandom_range(5, 24) : $urandom_range(1, 8);
				end
				run_left--;
				next_ready = !hold_low;
			end
			endcase
		end
		m_tready <= next_ready;
	end

	// ---- watchdog ----

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d writes still pending",
				cycle_count, writes_due.size());
			$display("** nmea_sentence_field_parser_core: FAILED **");
			$finish;
		end
	end

	// ---- stimulus and end of run ----

	initial begin
		int r;
		int picks;
		int nseen;
		parser_reset();

		// directed: idle extremes, one sentence of each kind, the broken type cases
		push_char(8'h00);
		push_char(8'hFF);
		push_text("$GPGGA,,,,,1,08,,545.4*");
		push_text("$GPRMC,0959,A*");
		push_text("$GPGSA,A,3,04,,*");
		push_text("$GPGSV,2,1,08,01,40,083,46*");
		push_text("$GPXYZ,$");      // unknown type eats the '$' after its comma
		push_text("$GPGGAXY");      // sixth type character drops the sentence
		push_text("$G*");           // star inside the type

		// satellites-used field far past the array and the position counter, after a drain
		stim_bytes.push_back({1'b1, CH_DOLLAR});
		push_text("GPGGA");
		repeat (7) push_char(CH_COMMA);
		repeat (270) push_char(field_byte());
		push_char(CH_STAR);

		// gsa with more commas than the field counter can hold
		push_text("$GPGSA,");
		repeat (300) begin
			push_char(CH_COMMA);
			if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) push_char(field_byte());
		end
		push_char(CH_STAR);

		// random part: mostly well-formed sentences, some broken, some line noise
		sentence_bytes = 0;
		picks = 0;
		while (sentence_bytes < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				case ($urandom_range(0, 3))
				0: push_sentence(KIND_GGA, picks == 0 || $urandom_range(0, 99) < 3);
				1: push_sentence(KIND_GSA, picks == 0 || $urandom_range(0, 99) < 3);
				2: push_sentence(KIND_GSV, picks == 0 || $urandom_range(0, 99) < 3);
				default: push_sentence(KIND_RMC, picks == 0 || $urandom_range(0, 99) < 3);
				endcase
			end else if (r < 80) begin
				// short type: kind comes from the letters kept from earlier sentences
				push_char(CH_DOLLAR);
				repeat ($urandom_range(0, 4)) push_char(any_letter());
				push_char(CH_COMMA);
				push_body(KIND_GSV, $urandom_range(1, 12));
			end else if (r < 85) begin
				// random five-letter type, often unknown
				push_char(CH_DOLLAR);
				repeat (5) push_char(any_letter());
				push_char(CH_COMMA);
				if ($urandom_range(0, 1)) push_char(CH_DOLLAR);
				push_body(KIND_GGA, $urandom_range(1, 10));
			end else if (r < 90) begin
				// overlong type or a star inside the type
				push_char(CH_DOLLAR);
				if ($urandom_range(0, 1)) repeat ($urandom_range(6, 8)) push_char(any_letter());
				else begin
					repeat ($urandom_range(0, 5)) push_char(any_letter());
					push_char(CH_STAR);
				end
				push_body(KIND_RMC, $urandom_range(1, 6));
			end else begin
				// line noise over the whole byte range
				repeat ($urandom_range(1, 10)) stim_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
			end
			picks++;
		end

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_bytes.size() != 0 || s_tvalid) @(posedge clk);
		while (writes_due.size() != 0) @(posedge clk);
		repeat (TAIL_TICKS) @(posedge clk);

		nseen = 0;
		for (int c = 0; c < 32; c++) if (codes_seen[c]) nseen++;
		$display("run took %0d bytes in %0d cycles, %0d generated sentences",
			bytes_taken, cycle_count, sentence_count);
		$display("%0d field writes checked, %0d distinct field codes, %0d mismatches",
			writes_seen, nseen, fail_count);
		if (fail_count == 0)
			$display("** nmea_sentence_field_parser_core: PASSED **");
		else
			$display("** nmea_sentence_field_parser_core: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/nsfp_pkg.sv
hw/rtl/nsfp_step.sv
hw/rtl/nmea_sentence_field_parser_core.sv
tb/nmea_sentence_field_parser_core_tb.sv
